// File: rtl/qpst_pkg.sv
// Shared types, constants and the lookup table for the quadrature position and speed tracker.
// No dependencies; every other file of the block imports this package.
package qpst_pkg;

   // Request codes carried in the req_type field.
   localparam logic [1:0] REQ_EDGE     = 2'd0;
   localparam logic [1:0] REQ_CLEAR    = 2'd1;
   localparam logic [1:0] REQ_BASELINE = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_TWO_CHANNEL     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_METERS_PER_COUNT = 1'b1;

   // Configuration reset values.
   localparam logic        TWO_CHANNEL_RESET     = 1'b1;
   localparam logic [23:0] METERS_PER_COUNT_RESET = 24'd16777;

   // Default timebase of the event timestamps.
   localparam int TIMEBASE_HZ_DEFAULT = 1000000;

   // The time step divisor is a positive signed 32-bit value.
   localparam int DEN_W = 31;

   // Speed saturation bounds, signed Q15.24.
   localparam logic signed [39:0] SPEED_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [39:0] SPEED_MIN = 40'sh80_0000_0000;

   // Quadrature transition table indexed by {previous state, new state}.
   localparam logic signed [1:0] QUAD_DELTA [16] = '{
       2'sd0, -2'sd1,  2'sd1,  2'sd0,
       2'sd1,  2'sd0,  2'sd0, -2'sd1,
      -2'sd1,  2'sd0,  2'sd0,  2'sd1,
       2'sd0,  2'sd1, -2'sd1,  2'sd0
   };

   typedef struct packed {
      logic [1:0]  req_type;
      logic        level_a;
      logic        level_b;
      logic [31:0] event_time_us;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] count_now;
      logic signed [55:0] distance_now;
      logic signed [39:0] speed_now;
      logic               sample_valid;
   } rsp_payload_type;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: rtl/qpst_div.sv
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on qpst_pkg for the status struct.
module qpst_div
   import qpst_pkg::*;
#(
   parameter int NUM_W = 44,
   parameter int DIV_W = DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output div_status_type   status,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   rem_shift;
   logic [DIV_W:0]   rem_sub;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_sub   = rem_shift - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits DIV_W bits.
         rem_in = fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// File: rtl/quadrature_position_speed_tracker.sv
// Top level of the quadrature position and speed tracker: sequencer, state and output register.
// Depends on qpst_pkg and instantiates the shared divider qpst_div.
//
// Each request carries the A and B line levels and a timestamp. An edge request updates the
// saturating position count from the quadrature transition table (or by one in single-channel
// mode), and when the wrapped time step is positive it computes a new speed as
// (distance change * TIMEBASE_HZ) / time step, truncated toward zero and saturated to signed
// Q15.24 m/s. A clear request zeroes count, speed, timestamp and the valid flag; a baseline
// request loads the previous line state. Every request yields exactly one result holding the
// count, the distance (count times meters_per_count, signed Q31.24) and the speed. The block
// works on one request at a time. An edge request with a positive time step passes through
// ST_SCALE, ST_DIVIDE and ST_FINISH; in ST_DIVIDE the shared restoring divider yields one
// quotient bit per cycle over a dividend of NUM_W = 24 + clog2(TIMEBASE_HZ + 1) bits (44 bits
// at the default 1 MHz timebase). Other requests skip ST_DIVIDE. A finished result waits in the
// output register while the next request is accepted.
module quadrature_position_speed_tracker
   import qpst_pkg::*;
#(
   parameter int TIMEBASE_HZ = TIMEBASE_HZ_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // The dividend is meters_per_count times the timebase.
   localparam int NUM_W = 24 + $clog2(TIMEBASE_HZ + 1);
   localparam int EXT_W = (NUM_W > 41) ? NUM_W : 41;
   localparam logic [NUM_W-1:0] TIMEBASE_K = NUM_W'(TIMEBASE_HZ);
   localparam logic [EXT_W-1:0] LIM_POS    = EXT_W'(40'h7F_FFFF_FFFF);
   localparam logic [EXT_W-1:0] LIM_NEG    = EXT_W'(40'h80_0000_0000);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCALE  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic        two_channel_ff;
   logic [23:0] mpc_ff;

   // Architectural state.
   logic [1:0]         line_prev_ff, line_prev_in;
   logic signed [31:0] count_ff, count_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic signed [39:0] speed_ff, speed_in;
   logic               valid_ff, valid_in;

   // Per-request working registers.
   logic [31:0] step_ff, step_in;
   logic        speed_upd_ff, speed_upd_in;
   logic        moved_ff, moved_in;
   logic        moved_neg_ff, moved_neg_in;
   logic signed [55:0] dist_ff, dist_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Datapath.
   logic [1:0]         line_now;
   logic signed [1:0]  delta;
   logic signed [32:0] count_sum;
   logic signed [31:0] count_sat;
   logic [31:0]        step_raw;
   logic signed [56:0] dist_prod;
   logic [NUM_W-1:0]   dividend;
   logic               div_start;
   div_status_type     div_status;
   logic [NUM_W-1:0]   quotient;
   logic [EXT_W-1:0]   quo_ext;
   logic               accept;
   logic               out_free;

   qpst_div #(
      .NUM_W (NUM_W),
      .DIV_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (step_ff[DEN_W-1:0]),
      .status   (div_status),
      .quotient (quotient)
   );

   // Configuration writes must arrive only while no request is in flight; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         two_channel_ff <= TWO_CHANNEL_RESET;
         mpc_ff         <= METERS_PER_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TWO_CHANNEL:      two_channel_ff <= csr_write_data[0];
            CSR_METERS_PER_COUNT: mpc_ff         <= csr_write_data;
            default:              ;
         endcase
      end
   end

   always_comb begin
      accept   = req_valid && (state_ff == ST_IDLE);
      out_free = !rsp_valid_ff || !rsp_stall;

      // Line B reads as inactive in single-channel mode.
      line_now = {req_data.level_a, req_data.level_b & two_channel_ff};
      delta    = two_channel_ff ? QUAD_DELTA[{line_prev_ff, line_now}] : 2'sd1;
      count_sum = 33'(count_ff) + 33'(delta);
      if (count_sum > 33'sd2147483647) begin
         count_sat = 32'sh7FFF_FFFF;
      end else if (count_sum < -33'sd2147483648) begin
         count_sat = 32'sh8000_0000;
      end else begin
         count_sat = count_sum[31:0];
      end
      step_raw = req_data.event_time_us - last_time_ff;

      // Distance uses the count after the request; an edge request changes the count by at most one,
      // so its distance change is zero or plus or minus meters_per_count.
      dist_prod = count_ff * $signed({1'b0, mpc_ff});
      dividend  = moved_ff ? (NUM_W'(mpc_ff) * TIMEBASE_K) : '0;
      quo_ext   = EXT_W'(quotient);

      state_in     = state_ff;
      line_prev_in = line_prev_ff;
      count_in     = count_ff;
      last_time_in = last_time_ff;
      speed_in     = speed_ff;
      valid_in     = valid_ff;
      step_in      = step_ff;
      speed_upd_in = speed_upd_ff;
      moved_in     = moved_ff;
      moved_neg_in = moved_neg_ff;
      dist_in      = dist_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               speed_upd_in = 1'b0;
               state_in     = ST_SCALE;
               unique case (req_data.req_type)
                  REQ_EDGE: begin
                     count_in     = count_sat;
                     moved_in     = count_sat != count_ff;
                     moved_neg_in = count_sat < count_ff;
                     step_in      = step_raw;
                     // Only a positive wrapped time step refreshes the speed.
                     speed_upd_in = !step_raw[31] && (step_raw != 32'd0);
                     last_time_in = req_data.event_time_us;
                     line_prev_in = line_now;
                     valid_in     = 1'b1;
                  end
                  REQ_CLEAR: begin
                     count_in     = '0;
                     speed_in     = '0;
                     last_time_in = '0;
                     valid_in     = 1'b0;
                  end
                  REQ_BASELINE: begin
                     line_prev_in = line_now;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCALE: begin
            dist_in = dist_prod[55:0];
            if (speed_upd_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               // Apply the sign of the distance change and saturate to Q15.24.
               if (moved_neg_ff) begin
                  speed_in = (quo_ext > LIM_NEG) ? SPEED_MIN : -$signed(quo_ext[39:0]);
               end else begin
                  speed_in = (quo_ext > LIM_POS) ? SPEED_MAX : $signed(quo_ext[39:0]);
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.count_now    = count_ff;
               rsp_data_in.distance_now = dist_ff;
               rsp_data_in.speed_now    = speed_ff;
               rsp_data_in.sample_valid = valid_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         line_prev_ff <= '0;
         count_ff     <= '0;
         last_time_ff <= '0;
         speed_ff     <= '0;
         valid_ff     <= 1'b0;
         speed_upd_ff <= 1'b0;
         moved_ff     <= 1'b0;
         moved_neg_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_prev_ff <= line_prev_in;
         count_ff     <= count_in;
         last_time_ff <= last_time_in;
         speed_ff     <= speed_in;
         valid_ff     <= valid_in;
         speed_upd_ff <= speed_upd_in;
         moved_ff     <= moved_in;
         moved_neg_ff <= moved_neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      dist_ff     <= dist_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: test/quadrature_position_speed_tracker_test.sv
// Self-checking testbench for quadrature_position_speed_tracker: a request queue drives a
// clocked driver and a clocked monitor checks every result against a built-in tracker model.
// Depends only on qpst_pkg and the block itself.
module quadrature_position_speed_tracker_test;
   import qpst_pkg::*;

   // Request code 3 has no name in the package; the block must only report on it.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam longint TICK_RATE   = TIMEBASE_HZ_DEFAULT;
   localparam longint COUNT_HI    = 64'sd2147483647;
   localparam longint COUNT_LO    = -64'sd2147483648;
   localparam longint SPEED_HI    = 64'sd549755813887;
   localparam longint SPEED_LO    = -64'sd549755813888;
   localparam int     CYCLE_LIMIT = 1000000;

   // Both sides run without any idling in this window, and the receiver holds off
   // completely for a long stretch starting at HOLD_START.
   localparam int CALM_FROM   = 3000;
   localparam int CALM_TO     = 9000;
   localparam int HOLD_START  = 12000;
   localparam int HOLD_CYCLES = 500;

   // Count change indexed by {previous lines, new lines}, lines being {A, B}.
   localparam int STEP_TABLE [16] = '{
       0, -1,  1,  0,
       1,  0,  0, -1,
      -1,  0,  0,  1,
       0,  1, -1,  0
   };

   // Forward quadrature order of the line states, and the position of each state in it.
   localparam logic [1:0] GRAY_ORDER [4] = '{2'd0, 2'd2, 2'd3, 2'd1};
   localparam int         GRAY_POS   [4] = '{0, 3, 1, 2};

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   req_payload_type        req_data         = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   quadrature_position_speed_tracker #(
      .TIMEBASE_HZ(TIMEBASE_HZ_DEFAULT)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // Requests waiting to be offered, and the results that accepted requests must produce.
   req_payload_type pending_requests [$];
   rsp_payload_type expected_results [$];

   int cycle_count     = 0;
   int requests_queued = 0;
   int results_seen    = 0;
   int error_count     = 0;
   int hold_left       = 0;

   // Tracker model: configuration copy and state, updated as requests are accepted.
   logic        cfg_two_channel = TWO_CHANNEL_RESET;
   logic [23:0] cfg_mpc         = METERS_PER_COUNT_RESET;
   logic [1:0]  line_prev       = 2'd0;
   longint      pos_count       = 0;
   logic [31:0] last_time       = 32'd0;
   longint      speed_est       = 0;
   logic        seen_edge       = 1'b0;

   // Tallies for the closing summary.
   int n_edges     = 0;
   int n_clears    = 0;
   int n_baselines = 0;
   int n_unused    = 0;
   int n_speed_new = 0;
   int n_speed_sat = 0;
   int n_held      = 0;

   // Stimulus generator state: position in the quadrature cycle, direction and clock.
   int          gen_pos  = 0;
   int          gen_dir  = 1;
   logic [31:0] gen_time = 32'd0;

   // Applies one request to the tracker model and returns the result it must report.
   function automatic rsp_payload_type track_request(input req_payload_type r);
      logic [1:0]      lines_now;
      longint          scale;
      longint          old_count;
      longint          moved;
      longint          rate;
      longint          distance;
      int              dt;
      rsp_payload_type res;
      scale     = longint'({40'd0, cfg_mpc});
      lines_now = {r.level_a, r.level_b & cfg_two_channel};
      case (r.req_type)
         REQ_EDGE: begin
            n_edges++;
            old_count = pos_count;
            moved     = cfg_two_channel ? longint'(STEP_TABLE[{line_prev, lines_now}]) : 1;
            pos_count = old_count + moved;
            if (pos_count > COUNT_HI) pos_count = COUNT_HI;
            if (pos_count < COUNT_LO) pos_count = COUNT_LO;
            // The time step is the wrapped difference read as a signed 32-bit value;
            // a zero or negative step keeps the previous speed.
            dt = r.event_time_us - last_time;
            if (dt > 0) begin
               rate = (pos_count - old_count) * scale * TICK_RATE / longint'(dt);
               n_speed_new++;
               if (rate > SPEED_HI || rate < SPEED_LO) n_speed_sat++;
               if (rate > SPEED_HI) rate = SPEED_HI;
               if (rate < SPEED_LO) rate = SPEED_LO;
               speed_est = rate;
            end else begin
               n_held++;
            end
            last_time = r.event_time_us;
            seen_edge = 1'b1;
            line_prev = lines_now;
         end
         REQ_CLEAR: begin
            n_clears++;
            pos_count = 0;
            speed_est = 0;
            last_time = 32'd0;
            seen_edge = 1'b0;
         end
         REQ_BASELINE: begin
            n_baselines++;
            line_prev = lines_now;
         end
         default: begin
            n_unused++;
         end
      endcase
      distance         = pos_count * scale;
      res.count_now    = pos_count[31:0];
      res.distance_now = distance[55:0];
      res.speed_now    = speed_est[39:0];
      res.sample_valid = seen_edge;
      return res;
   endfunction

   task automatic queue_request(input logic [1:0] kind, input logic [1:0] lines,
                                input logic [31:0] stamp);
      req_payload_type r;
      r.req_type      = kind;
      r.level_a       = lines[1];
      r.level_b       = lines[0];
      r.event_time_us = stamp;
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   // Moves the generator clock: mostly short and medium steps, sometimes no step,
   // a jump anywhere in the 32-bit range, or a step backward.
   function automatic logic [31:0] advance_time();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) gen_time += $urandom_range(100, 1);
      else if (pick < 78) gen_time += $urandom_range(100000, 100);
      else if (pick < 88) gen_time = gen_time;
      else if (pick < 94) gen_time = $urandom();
      else gen_time -= $urandom_range(5000, 1);
      return gen_time;
   endfunction

   // Random traffic: mostly clean quadrature motion with direction reversals, mixed with
   // arbitrary line jumps, clears, baselines, the unused code and one-tick steps.
   task automatic run_random(input int n);
      int unsigned pick;
      logic [1:0]  lines;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 68) begin
            if ($urandom_range(99) < 15) gen_dir = -gen_dir;
            gen_pos = (gen_pos + gen_dir) & 3;
            queue_request(REQ_EDGE, GRAY_ORDER[gen_pos], advance_time());
         end else if (pick < 78) begin
            lines   = 2'($urandom());
            gen_pos = GRAY_POS[lines];
            queue_request(REQ_EDGE, lines, advance_time());
         end else if (pick < 83) begin
            queue_request(REQ_CLEAR, 2'($urandom()), $urandom());
         end else if (pick < 89) begin
            lines   = 2'($urandom());
            gen_pos = GRAY_POS[lines];
            queue_request(REQ_BASELINE, lines, $urandom());
         end else if (pick < 92) begin
            queue_request(REQ_UNUSED, 2'($urandom()), $urandom());
         end else begin
            gen_pos  = (gen_pos + gen_dir) & 3;
            gen_time += 1;
            queue_request(REQ_EDGE, GRAY_ORDER[gen_pos], gen_time);
         end
      end
   endtask

   // Register writes happen only while the block is idle, so the model copy follows at once.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [23:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_TWO_CHANNEL) cfg_two_channel = value[0];
      else cfg_mpc = value;
   endtask

   // Waits until every queued request has produced its result, then idles briefly before returning.
   task automatic drain();
      while (results_seen < requests_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Sender: offers the next queued request unless it decides to idle this cycle. A request
   // that is still stalled stays on the bus unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_results.push_back(track_request(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 &&
                !((cycle_count < CALM_FROM || cycle_count >= CALM_TO) &&
                  $urandom_range(99) < 19)) begin
               req_data  <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: random idling outside the calm window, plus one long hold-off that
   // fills the block and pushes back on the sender.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (cycle_count == HOLD_START) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_stall <= (cycle_count < CALM_FROM || cycle_count >= CALM_TO) &&
                      ($urandom_range(99) < 19);
      end
   end

   // Result checker: every accepted result is compared with the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("result with no request outstanding: count_now %0d", rsp_data.count_now);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.count_now !== want.count_now) begin
               $error("count_now: expected %0d, got %0d", want.count_now, rsp_data.count_now);
               error_count++;
            end
            if (rsp_data.distance_now !== want.distance_now) begin
               $error("distance_now: expected %0d, got %0d",
                      want.distance_now, rsp_data.distance_now);
               error_count++;
            end
            if (rsp_data.speed_now !== want.speed_now) begin
               $error("speed_now: expected %0d, got %0d", want.speed_now, rsp_data.speed_now);
               error_count++;
            end
            if (rsp_data.sample_valid !== want.sample_valid) begin
               $error("sample_valid: expected %0b, got %0b",
                      want.sample_valid, rsp_data.sample_valid);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d of %0d results received.",
                  cycle_count, results_seen, requests_queued);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset configuration (two channels, reset scale).
      // The unused code must report the all-zero state.
      queue_request(REQ_UNUSED, 2'b11, 32'hFFFF_FFFF);
      // Sixteen REQ_EDGE requests that walk every transition of the table once, starting from state 0:
      // the first has a zero time step, the rest have growing positive steps.
      begin : walk_all_transitions
         logic [1:0] walk [16];
         walk = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
                  2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
         for (int i = 0; i < 16; i++) queue_request(REQ_EDGE, walk[i], 32'(i * i * 37));
      end
      // Same timestamp again, then an earlier one: both keep the previous speed.
      queue_request(REQ_EDGE, 2'd2, 32'd8325);
      queue_request(REQ_EDGE, 2'd3, 32'd8225);
      // The largest positive step, then a step of exactly half the range, which reads as
      // negative, then another negative step, then a step that wraps past zero.
      queue_request(REQ_EDGE, 2'd1, 32'h7FFF_FFFF + 32'd8225);
      queue_request(REQ_EDGE, 2'd0, 32'h7FFF_FFFF + 32'd8225 + 32'h8000_0000);
      queue_request(REQ_EDGE, 2'd2, 32'hFFFF_FFFF);
      queue_request(REQ_EDGE, 2'd3, 32'h0000_000F);
      // Clear keeps the line state; a baseline then moves it without counting.
      queue_request(REQ_CLEAR, 2'b11, 32'hA5A5_5A5A);
      queue_request(REQ_BASELINE, 2'b11, 32'd0);
      queue_request(REQ_EDGE, 2'b10, 32'd5);
      drain();

      // Largest scale: single-tick steps in both directions drive the speed to its bounds.
      write_register(CSR_TWO_CHANNEL, {23'($urandom()), 1'b1});
      write_register(CSR_METERS_PER_COUNT, 24'hFF_FFFF);
      gen_pos  = 0;
      queue_request(REQ_BASELINE, GRAY_ORDER[0], 32'd0);
      queue_request(REQ_EDGE, GRAY_ORDER[1], 32'd6);
      queue_request(REQ_EDGE, GRAY_ORDER[0], 32'd7);
      gen_time = 32'd7;
      run_random(300);
      drain();

      // Single-channel mode with a zero scale: counts rise but distance and speed stay zero.
      write_register(CSR_TWO_CHANNEL, {23'($urandom()), 1'b0});
      write_register(CSR_METERS_PER_COUNT, 24'd0);
      run_random(200);
      drain();

      write_register(CSR_METERS_PER_COUNT, 24'($urandom()));
      run_random(250);
      drain();

      write_register(CSR_TWO_CHANNEL, {23'($urandom()), 1'b1});
      write_register(CSR_METERS_PER_COUNT, 24'($urandom()));
      run_random(300);
      drain();

      write_register(CSR_METERS_PER_COUNT, 24'd1);
      run_random(300);
      drain();

      repeat (20) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         error_count++;
      end
      $display("Run covered %0d requests: %0d edges, %0d clears, %0d baselines, %0d unused.",
               results_seen, n_edges, n_clears, n_baselines, n_unused);
      $display("Speed was recomputed %0d times (%0d clipped) and held on %0d edges.",
               n_speed_new, n_speed_sat, n_held);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
